@@ rtl/core/voxel_cube_draw_engine_macros.svh @@
// Assertion macros for the voxel cube draw engine.
// Expects clk and rst_n in the scope of each use; no other dependencies.
`ifndef VOXEL_CUBE_DRAW_ENGINE_MACROS_SVH
`define VOXEL_CUBE_DRAW_ENGINE_MACROS_SVH
`ifndef ASSERT_OFF
// Plain invariant, checked on every clock edge outside reset.
`define VCDE_ASSERT(lbl, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
    else $error("vcde invariant violated");
// Implication: when ante holds, cons must hold in the same cycle.
`define VCDE_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("vcde implication violated");
`else
`define VCDE_ASSERT(lbl, cond)
`define VCDE_ASSERT_IMP(lbl, ante, cons)
`endif
`endif

@@ rtl/core/vcde_pkg.sv @@
// Shared types, constants and helpers for the voxel cube draw engine.
// No dependencies; imported by every module of the block.
package vcde_pkg;

  localparam int CUBE_EDGE  = 8;
  localparam int FRAME_ROWS = 64;
  localparam int ROW_W      = 8;
  localparam int COORD_W    = 3;
  localparam int ROW_IDX_W  = $clog2(FRAME_ROWS);
  localparam int MEM_AW     = ROW_IDX_W + 1;
  localparam int MEM_DEPTH  = 2 * FRAME_ROWS;

  localparam logic [COORD_W:0]   EDGE_N   = (COORD_W + 1)'(CUBE_EDGE);
  localparam logic [COORD_W-1:0] EDGE_M1  = COORD_W'(CUBE_EDGE - 1);
  localparam logic [COORD_W-1:0] HALF_M1  = COORD_W'(CUBE_EDGE / 2 - 1);
  localparam logic [ROW_W-1:0]   FULL_ROW = ROW_W'((1 << CUBE_EDGE) - 1);
  localparam logic [ROW_W-1:0]   ONE_BIT  = ROW_W'(1);

  typedef enum logic [3:0] {
    OP_FILL    = 4'd0,
    OP_ON      = 4'd1,
    OP_OFF     = 4'd2,
    OP_INV     = 4'd3,
    OP_PLANE_X = 4'd4,
    OP_PLANE_Y = 4'd5,
    OP_PLANE_Z = 4'd6,
    OP_MIR_X   = 4'd7,
    OP_MIR_Y   = 4'd8,
    OP_MIR_Z   = 4'd9,
    OP_BOX     = 4'd10,
    OP_READ    = 4'd11
  } vcde_op_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_RMW,
    ST_DRAIN,
    ST_SW_RDA,
    ST_SW_RDB,
    ST_SW_WRA,
    ST_SW_WRB,
    ST_RD,
    ST_FINISH
  } vcde_state_t;

  typedef struct packed {
    logic                re;
    logic [MEM_AW-1:0]   raddr;
    logic                we;
    logic [MEM_AW-1:0]   waddr;
    logic [ROW_W-1:0]    wdata;
  } vcde_mem_req_t;

  function automatic logic in_edge(input logic [COORD_W-1:0] c);
    return {1'b0, c} < EDGE_N;
  endfunction

  // Row index z*EDGE + y, wrapped to the frame depth.
  function automatic logic [ROW_IDX_W-1:0] row_at(input logic [COORD_W-1:0] y,
                                                  input logic [COORD_W-1:0] z);
    logic [9:0] s;
    s = 10'(z) * 10'(CUBE_EDGE) + 10'(y);
    return s[ROW_IDX_W-1:0];
  endfunction

endpackage

@@ rtl/core/vcde_frame_mem.sv @@
// Frame memory: both frames in one single-write, single-read array.
// Per-entry valid bits make never-written rows read as zero. Uses vcde_pkg.
module vcde_frame_mem
  import vcde_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  vcde_mem_req_t    req,
  output logic [ROW_W-1:0] rdata
);

  logic [ROW_W-1:0]     mem [MEM_DEPTH];
  logic [MEM_DEPTH-1:0] vld_r;
  logic [ROW_W-1:0]     rdata_r;
  logic                 rvld_r;

  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.waddr] <= req.wdata;
    end
    if (req.re) begin
      rdata_r <= mem[req.raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r  <= '0;
      rvld_r <= 1'b0;
    end else begin
      if (req.we) begin
        vld_r[req.waddr] <= 1'b1;
      end
      if (req.re) begin
        rvld_r <= vld_r[req.raddr];
      end
    end
  end

  assign rdata = rvld_r ? rdata_r : '0;

endmodule

@@ rtl/core/vcde_row_alu.sv @@
// Shared row unit: turns one old row byte into its new value per command.
// Purely combinational; uses vcde_pkg.
module vcde_row_alu
  import vcde_pkg::*;
(
  input  vcde_op_t           op,
  input  logic [ROW_W-1:0]   old_row,
  input  logic [COORD_W-1:0] bit_pos,
  input  logic               voxel_on,
  input  logic [ROW_W-1:0]   pattern,
  input  logic [COORD_W-1:0] span_lo,
  input  logic [COORD_W-1:0] span_hi,
  output logic [ROW_W-1:0]   new_row
);

  logic [ROW_W-1:0] bit_m;
  logic [ROW_W-1:0] span_m;
  logic [ROW_W-1:0] rev_row;

  always_comb begin
    bit_m   = ONE_BIT << bit_pos;
    span_m  = '0;
    rev_row = '0;
    for (int i = 0; i < ROW_W; i++) begin
      span_m[i] = (COORD_W'(i) >= span_lo) && (COORD_W'(i) <= span_hi);
    end
    // only the low CUBE_EDGE bits are voxels
    for (int i = 0; i < CUBE_EDGE; i++) begin
      rev_row[CUBE_EDGE-1-i] = old_row[i];
    end
  end

  always_comb begin
    unique case (op)
      OP_FILL:    new_row = pattern & FULL_ROW;
      OP_ON:      new_row = old_row | bit_m;
      OP_OFF:     new_row = old_row & ~bit_m;
      OP_INV:     new_row = old_row ^ bit_m;
      OP_PLANE_X: new_row = voxel_on ? (old_row | bit_m) : (old_row & ~bit_m);
      OP_PLANE_Y,
      OP_PLANE_Z: new_row = voxel_on ? FULL_ROW : '0;
      OP_MIR_X:   new_row = rev_row;
      OP_BOX:     new_row = old_row | span_m;
      default:    new_row = old_row;
    endcase
  end

endmodule

@@ rtl/core/voxel_cube_draw_engine.sv @@
// Top level of the voxel cube draw engine: command sequencer and result register.
// Depends on vcde_pkg, vcde_frame_mem, vcde_row_alu and the assertion macro header.
//
// Commands arrive on the in_ channel (valid/stall); a transaction is taken when
// in_valid is high and in_stall is low. Each command gives exactly one out_
// transaction: out_row_data (row byte for a read, else zero), out_done_res = 1.
// One command is worked at a time; in_stall stays high from acceptance until
// the result is parked in the output register.
// Each command walks its rows through the frame memory before its result is parked:
//   fill, plane x, mirror x: all 64 rows, one per cycle; plane y: one row per layer;
//   plane z: one layer; box: the rows in the box; mirror y/z: 32 swaps, each two reads
//   then two writes; voxel set/clear/invert: one row; read: one row; no-op or
//   out-of-cube command: no rows.
// The single frame memory allows one registered read and one write per cycle.
// A finished result may wait under out_stall while the next command is taken and
// worked; that command holds in its last cycle until the register is free.
// Reset (rst_n, synchronous, active low) empties the output register and clears
// the per-row valid bits, so both frames read as all zero at once; no clearing pass.
`include "voxel_cube_draw_engine_macros.svh"

module voxel_cube_draw_engine
  import vcde_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  // command channel
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [3:0]         in_op,
  input  logic [COORD_W-1:0] in_x,
  input  logic [COORD_W-1:0] in_y,
  input  logic [COORD_W-1:0] in_z,
  input  logic [COORD_W-1:0] in_x_end,
  input  logic [COORD_W-1:0] in_y_end,
  input  logic [COORD_W-1:0] in_z_end,
  input  logic               in_voxel_on,
  input  logic [ROW_W-1:0]   in_pattern,
  input  logic               in_target,
  // result channel
  output logic               out_valid,
  input  logic               out_stall,
  output logic [ROW_W-1:0]   out_row_data,
  output logic               out_done_res
);

  vcde_state_t        state_r, state_nxt;
  vcde_op_t           op_r;
  logic               target_r;
  logic [COORD_W-1:0] x_r;
  logic               on_r;
  logic [ROW_W-1:0]   pattern_r;
  logic [COORD_W-1:0] span_lo_r, span_hi_r;
  logic               rd_hit_r;

  // row walk: a is the outer (z-like) counter, b the inner (y-like) one
  logic [COORD_W-1:0] a_r, a_nxt, a_hi_r;
  logic [COORD_W-1:0] b_r, b_nxt, b_lo_r, b_hi_r;

  logic               pend_r;
  logic [MEM_AW-1:0]  pend_addr_r;
  logic [ROW_W-1:0]   hold_r;

  logic               out_valid_r, out_valid_nxt;
  logic [ROW_W-1:0]   out_row_data_r;
  logic               out_done_res_r;

  // start decode
  vcde_op_t           in_opc;
  vcde_state_t        start_st;
  logic [COORD_W-1:0] start_a_lo, start_a_hi, start_b_lo, start_b_hi;
  logic [COORD_W-1:0] x_lo, x_hi, y_lo, y_hi, z_lo, z_hi;
  logic               voxel_in, box_in;

  logic               accept;
  logic               last_pos;
  logic               step;
  logic               res_load;

  logic [MEM_AW-1:0]  addr_a, addr_b;
  logic [COORD_W-1:0] a_mir, b_mir;
  vcde_mem_req_t      mem_req;
  logic [ROW_W-1:0]   mem_rdata;
  logic [ROW_W-1:0]   alu_row;

  assign in_stall  = (state_r != ST_IDLE);
  assign accept    = in_valid && !in_stall;
  assign last_pos  = (a_r == a_hi_r) && (b_r == b_hi_r);
  assign step      = (state_r == ST_RMW) || (state_r == ST_SW_WRB);
  assign res_load  = (state_r == ST_FINISH) && (!out_valid_r || !out_stall);

  // ---- command decode at acceptance ----
  always_comb begin
    in_opc   = vcde_op_t'(in_op);
    x_lo     = (in_x <= in_x_end) ? in_x : in_x_end;
    x_hi     = (in_x <= in_x_end) ? in_x_end : in_x;
    y_lo     = (in_y <= in_y_end) ? in_y : in_y_end;
    y_hi     = (in_y <= in_y_end) ? in_y_end : in_y;
    z_lo     = (in_z <= in_z_end) ? in_z : in_z_end;
    z_hi     = (in_z <= in_z_end) ? in_z_end : in_z;
    voxel_in = in_edge(in_x) && in_edge(in_y) && in_edge(in_z);
    box_in   = voxel_in && in_edge(in_x_end) && in_edge(in_y_end) && in_edge(in_z_end);

    start_st   = ST_FINISH;
    start_a_lo = '0;
    start_a_hi = EDGE_M1;
    start_b_lo = '0;
    start_b_hi = EDGE_M1;
    unique case (in_opc)
      OP_FILL,
      OP_MIR_X: start_st = ST_RMW;
      OP_ON,
      OP_OFF,
      OP_INV: begin
        if (voxel_in) begin
          start_st   = ST_RMW;
          start_a_lo = in_z;
          start_a_hi = in_z;
          start_b_lo = in_y;
          start_b_hi = in_y;
        end
      end
      OP_PLANE_X: begin
        if (in_edge(in_x)) begin
          start_st = ST_RMW;
        end
      end
      OP_PLANE_Y: begin
        if (in_edge(in_x)) begin
          start_st   = ST_RMW;
          start_b_lo = in_x;
          start_b_hi = in_x;
        end
      end
      OP_PLANE_Z: begin
        if (in_edge(in_x)) begin
          start_st   = ST_RMW;
          start_a_lo = in_x;
          start_a_hi = in_x;
        end
      end
      OP_MIR_Y: begin
        start_st   = ST_SW_RDA;
        start_b_hi = HALF_M1;
      end
      OP_MIR_Z: begin
        start_st   = ST_SW_RDA;
        start_a_hi = HALF_M1;
      end
      OP_BOX: begin
        if (box_in) begin
          start_st   = ST_RMW;
          start_a_lo = z_lo;
          start_a_hi = z_hi;
          start_b_lo = y_lo;
          start_b_hi = y_hi;
        end
      end
      OP_READ: begin
        if (in_edge(in_y) && in_edge(in_z)) begin
          start_st   = ST_RD;
          start_a_lo = in_z;
          start_a_hi = in_z;
          start_b_lo = in_y;
          start_b_hi = in_y;
        end
      end
      default: start_st = ST_FINISH;
    endcase
  end

  // ---- next state ----
  always_comb begin
    unique case (state_r)
      ST_IDLE:   state_nxt = in_valid ? start_st : ST_IDLE;
      ST_RMW:    state_nxt = last_pos ? ST_DRAIN : ST_RMW;
      ST_DRAIN:  state_nxt = ST_FINISH;
      ST_SW_RDA: state_nxt = ST_SW_RDB;
      ST_SW_RDB: state_nxt = ST_SW_WRA;
      ST_SW_WRA: state_nxt = ST_SW_WRB;
      ST_SW_WRB: state_nxt = last_pos ? ST_FINISH : ST_SW_RDA;
      ST_RD:     state_nxt = ST_FINISH;
      ST_FINISH: state_nxt = res_load ? ST_IDLE : ST_FINISH;
      default:   state_nxt = ST_IDLE;
    endcase
  end

  // ---- row counters ----
  always_comb begin
    a_nxt = a_r;
    b_nxt = b_r;
    if (accept) begin
      a_nxt = start_a_lo;
      b_nxt = start_b_lo;
    end else if (step) begin
      if (b_r == b_hi_r) begin
        b_nxt = b_lo_r;
        a_nxt = a_r + COORD_W'(1);
      end else begin
        b_nxt = b_r + COORD_W'(1);
      end
    end
  end

  // ---- memory port control (state outputs) ----
  always_comb begin
    a_mir  = EDGE_M1 - a_r;
    b_mir  = EDGE_M1 - b_r;
    addr_a = {target_r, row_at(b_r, a_r)};
    // swap partner: mirrored y within the layer, or mirrored layer
    addr_b = (op_r == OP_MIR_Y) ? {target_r, row_at(b_mir, a_r)}
                                : {target_r, row_at(b_r, a_mir)};

    mem_req.re    = 1'b0;
    mem_req.raddr = addr_a;
    mem_req.we    = pend_r;
    mem_req.waddr = pend_addr_r;
    mem_req.wdata = alu_row;
    unique case (state_r)
      ST_RMW,
      ST_SW_RDA,
      ST_RD:     mem_req.re = 1'b1;
      ST_SW_RDB: begin
        mem_req.re    = 1'b1;
        mem_req.raddr = addr_b;
      end
      ST_SW_WRA: begin
        mem_req.we    = 1'b1;
        mem_req.waddr = addr_a;
        mem_req.wdata = mem_rdata;
      end
      ST_SW_WRB: begin
        mem_req.we    = 1'b1;
        mem_req.waddr = addr_b;
        mem_req.wdata = hold_r;
      end
      default: mem_req.re = 1'b0;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (res_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  // ---- control registers ----
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      // a row read in RMW is written back in the following cycle
      pend_r      <= (state_r == ST_RMW);
      out_valid_r <= out_valid_nxt;
    end
  end

  // ---- payload registers ----
  always_ff @(posedge clk) begin
    a_r <= a_nxt;
    b_r <= b_nxt;
    pend_addr_r <= addr_a;
    if (accept) begin
      op_r      <= in_opc;
      target_r  <= in_target;
      x_r       <= in_x;
      on_r      <= in_voxel_on;
      pattern_r <= in_pattern;
      span_lo_r <= x_lo;
      span_hi_r <= x_hi;
      a_hi_r    <= start_a_hi;
      b_lo_r    <= start_b_lo;
      b_hi_r    <= start_b_hi;
      rd_hit_r  <= (in_opc == OP_READ) && in_edge(in_y) && in_edge(in_z);
    end
    if (state_r == ST_SW_RDB) begin
      hold_r <= mem_rdata;
    end
    if (res_load) begin
      out_row_data_r <= rd_hit_r ? mem_rdata : '0;
      out_done_res_r <= 1'b1;
    end
  end

  vcde_frame_mem u_mem (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (mem_req),
    .rdata (mem_rdata)
  );

  vcde_row_alu u_alu (
    .op       (op_r),
    .old_row  (mem_rdata),
    .bit_pos  (x_r),
    .voxel_on (on_r),
    .pattern  (pattern_r),
    .span_lo  (span_lo_r),
    .span_hi  (span_hi_r),
    .new_row  (alu_row)
  );

  assign out_valid    = out_valid_r;
  assign out_row_data = out_row_data_r;
  assign out_done_res = out_done_res_r;

  // ---- assertions ----
  // no frame write may be issued while the engine is idle
  `VCDE_ASSERT(a_no_idle_write, !(state_r == ST_IDLE && mem_req.we))
  // a pending write-back only ever follows a read issued in RMW
  `VCDE_ASSERT_IMP(a_pend_from_rmw, pend_r, $past(state_r) == ST_RMW)
  // a result appears only after the finish step
  `VCDE_ASSERT_IMP(a_res_from_finish, $rose(out_valid_r), $past(state_r) == ST_FINISH)
  // the two halves of a mirror swap target different rows
  `VCDE_ASSERT_IMP(a_swap_rows_differ, state_r == ST_SW_WRB, addr_a != addr_b)

endmodule
